### sv/art_pkg.sv
// shared types and codes for the address region table
`default_nettype none
package art_pkg;

    localparam int ADDR_W  = 64;
    localparam int FLAGS_W = 8;
    localparam int SLOT_W  = 4;
    localparam int STAT_W  = 2;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } art_state_t;

    typedef enum logic [1:0] {
        OUT_INSERT,
        OUT_HIT,
        OUT_MISS,
        OUT_FULL
    } art_out_sel_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  start_addr;
        logic [ADDR_W-1:0]  end_addr;
        logic [FLAGS_W-1:0] flags;
        logic [ADDR_W-1:0]  file_offset;
        logic [ADDR_W-1:0]  file_bytes;
    } art_region_t;

    typedef struct packed {
        logic         rd_en;
        logic         wr_en;
        logic         cap_req;
        logic         out_load;
        art_out_sel_t out_sel;
    } art_cmd_t;

    typedef struct packed {
        logic match;
    } art_stat_t;

endpackage
`default_nettype wire

### sv/art_dp.sv
// region store, address compare and result registers
`default_nettype none
module art_dp #(
    parameter int MAX_REGIONS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire art_pkg::art_cmd_t                 cmd,
    input  wire logic [$clog2(MAX_REGIONS)-1:0]    rd_addr,
    input  wire logic [$clog2(MAX_REGIONS)-1:0]    wr_addr,
    input  wire logic [$clog2(MAX_REGIONS)-1:0]    out_slot,
    output art_pkg::art_stat_t                     stat,
    input  wire logic [art_pkg::ADDR_W-1:0]        address,
    input  wire logic [art_pkg::ADDR_W-1:0]        region_length,
    input  wire logic [art_pkg::FLAGS_W-1:0]       region_flags,
    input  wire logic [art_pkg::ADDR_W-1:0]        file_offset,
    input  wire logic [art_pkg::ADDR_W-1:0]        file_bytes,
    output logic [art_pkg::STAT_W-1:0]             status,
    output logic [art_pkg::SLOT_W-1:0]             slot,
    output logic [art_pkg::ADDR_W-1:0]             match_start,
    output logic [art_pkg::ADDR_W-1:0]             match_end,
    output logic [art_pkg::FLAGS_W-1:0]            match_flags,
    output logic [art_pkg::ADDR_W-1:0]             match_file_offset,
    output logic [art_pkg::ADDR_W-1:0]             match_file_bytes
);
    import art_pkg::*;

    art_region_t               mem [MAX_REGIONS];
    art_region_t               rd_data_reg;
    art_region_t               wr_data;
    logic [ADDR_W-1:0]         addr_reg;
    logic [STAT_W-1:0]         status_reg;
    logic [STAT_W-1:0]         status_next;
    logic [SLOT_W-1:0]         slot_reg;
    logic [SLOT_W-1:0]         slot_next;
    art_region_t               out_reg;
    art_region_t               out_next;

    assign wr_data.start_addr  = address;
    assign wr_data.end_addr    = address + region_length;
    assign wr_data.flags       = region_flags;
    assign wr_data.file_offset = file_offset;
    assign wr_data.file_bytes  = file_bytes;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.cap_req)
        begin
            addr_reg <= address;
        end
    end

    assign stat.match = (addr_reg >= rd_data_reg.start_addr) &&
                        (addr_reg < rd_data_reg.end_addr);

    always_comb
    begin
        status_next = STATUS_OK;
        slot_next   = '0;
        out_next    = '0;
        case (cmd.out_sel)
            OUT_INSERT:
            begin
                slot_next = SLOT_W'(out_slot);
                out_next  = wr_data;
            end
            OUT_HIT:
            begin
                slot_next = SLOT_W'(out_slot);
                out_next  = rd_data_reg;
            end
            OUT_MISS:
            begin
                status_next = STATUS_MISS;
            end
            OUT_FULL:
            begin
                status_next = STATUS_FULL;
            end
            default:
            begin
                status_next = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= STATUS_OK;
            slot_reg   <= '0;
            out_reg    <= '0;
        end
        else if (cmd.out_load)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            out_reg    <= out_next;
        end
    end

    assign status            = status_reg;
    assign slot              = slot_reg;
    assign match_start       = out_reg.start_addr;
    assign match_end         = out_reg.end_addr;
    assign match_flags       = out_reg.flags;
    assign match_file_offset = out_reg.file_offset;
    assign match_file_bytes  = out_reg.file_bytes;

endmodule
`default_nettype wire

### sv/art_ctrl.sv
// controller: fill count, scan sequencing and result strobe
`default_nettype none
module art_ctrl #(
    parameter int MAX_REGIONS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic                              req_type,
    output logic                                   busy,
    output logic                                   done,
    output art_pkg::art_cmd_t                      cmd,
    output logic [$clog2(MAX_REGIONS)-1:0]         rd_addr,
    output logic [$clog2(MAX_REGIONS)-1:0]         wr_addr,
    output logic [$clog2(MAX_REGIONS)-1:0]         out_slot,
    input  wire art_pkg::art_stat_t                stat
);
    import art_pkg::*;

    localparam int IDX_W = $clog2(MAX_REGIONS);
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);

    art_state_t         state_reg;
    art_state_t         state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   idx_next;
    logic               cmp_vld_reg;
    logic               cmp_vld_next;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic [IDX_W-1:0]   cmp_idx_next;
    logic               done_reg;
    logic               done_next;
    logic               accept;
    logic               full;
    logic               scan_hit;
    logic               scan_miss;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign full      = (count_reg == CNT_W'(MAX_REGIONS));
    assign scan_hit  = (state_reg == ST_SCAN) && cmp_vld_reg && stat.match;
    assign scan_miss = (state_reg == ST_SCAN) && !cmp_vld_reg && (idx_reg >= count_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == REQ_LOOKUP))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_hit || scan_miss)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.rd_en    = 1'b0;
        cmd.wr_en    = 1'b0;
        cmd.cap_req  = 1'b0;
        cmd.out_load = 1'b0;
        cmd.out_sel  = OUT_MISS;
        out_slot     = cmp_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                out_slot = count_reg[IDX_W-1:0];
                if (accept && (req_type == REQ_INSERT))
                begin
                    cmd.out_load = 1'b1;
                    cmd.wr_en    = !full;
                    cmd.out_sel  = full ? OUT_FULL : OUT_INSERT;
                end
                else if (accept)
                begin
                    cmd.cap_req = 1'b1;
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = (idx_reg < count_reg);
                if (scan_hit)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_HIT;
                end
                else if (scan_miss)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_MISS;
                end
            end
            default:
            begin
                cmd.rd_en = 1'b0;
            end
        endcase
    end

    assign rd_addr = idx_reg[IDX_W-1:0];
    assign wr_addr = count_reg[IDX_W-1:0];

    always_comb
    begin
        count_next   = cmd.wr_en ? count_reg + CNT_W'(1) : count_reg;
        idx_next     = (state_reg == ST_SCAN && cmd.rd_en) ? idx_reg + CNT_W'(1) :
                       (state_reg == ST_SCAN) ? idx_reg : '0;
        cmp_vld_next = (state_reg == ST_SCAN) && cmd.rd_en && !scan_hit;
        cmp_idx_next = idx_reg[IDX_W-1:0];
        done_next    = cmd.out_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            cmp_idx_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            cmp_vld_reg <= cmp_vld_next;
            cmp_idx_reg <= cmp_idx_next;
            done_reg    <= done_next;
        end
    end

    assign done = done_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_REGIONS))
        else $error("fill count above table size");

    a_cmp_filled: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> (CNT_W'(cmp_idx_reg) < count_reg))
        else $error("compare on unfilled slot");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_type == REQ_INSERT && !full) |=>
            (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not advance fill count");

    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && !cmp_vld_reg && idx_reg >= count_reg) |=>
            (done_reg && state_reg == ST_IDLE))
        else $error("exhausted scan did not finish");

endmodule
`default_nettype wire

### sv/address_region_table.sv
// top level of the address region table
`default_nettype none
// Table of up to MAX_REGIONS address regions, filled in slot order. Pulse start
// while busy is low to issue a transaction; its result appears for exactly one
// cycle with done high, and the receiver cannot stall it. An insert raises done
// in the cycle after it is accepted and may be followed at once by another
// transaction; an insert into a full table is dropped with status full. A
// lookup reads one slot per cycle from the single read port of the region
// store, in slot order, and ends on the first hit or when the filled slots are
// exhausted, at once on an empty table. busy is low again in the cycle that
// done is high.
module address_region_table #(
    parameter int MAX_REGIONS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          req_type,
    input  wire logic [art_pkg::ADDR_W-1:0]    address,
    input  wire logic [art_pkg::ADDR_W-1:0]    region_length,
    input  wire logic [art_pkg::FLAGS_W-1:0]   region_flags,
    input  wire logic [art_pkg::ADDR_W-1:0]    file_offset,
    input  wire logic [art_pkg::ADDR_W-1:0]    file_bytes,
    output logic                               done,
    output logic [art_pkg::STAT_W-1:0]         status,
    output logic [art_pkg::SLOT_W-1:0]         slot,
    output logic [art_pkg::ADDR_W-1:0]         match_start,
    output logic [art_pkg::ADDR_W-1:0]         match_end,
    output logic [art_pkg::FLAGS_W-1:0]        match_flags,
    output logic [art_pkg::ADDR_W-1:0]         match_file_offset,
    output logic [art_pkg::ADDR_W-1:0]         match_file_bytes
);
    import art_pkg::*;

    localparam int IDX_W = $clog2(MAX_REGIONS);

    art_cmd_t           cmd;
    art_stat_t          stat;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   out_slot;

    art_ctrl #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .busy     (busy),
        .done     (done),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .out_slot (out_slot),
        .stat     (stat)
    );

    art_dp #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .rd_addr           (rd_addr),
        .wr_addr           (wr_addr),
        .out_slot          (out_slot),
        .stat              (stat),
        .address           (address),
        .region_length     (region_length),
        .region_flags      (region_flags),
        .file_offset       (file_offset),
        .file_bytes        (file_bytes),
        .status            (status),
        .slot              (slot),
        .match_start       (match_start),
        .match_end         (match_end),
        .match_flags       (match_flags),
        .match_file_offset (match_file_offset),
        .match_file_bytes  (match_file_bytes)
    );

endmodule
`default_nettype wire

### test/tb.sv
// self-checking testbench for the address region table: directed rows, then random traffic
`timescale 1ns / 1ps

module tb;

    import art_pkg::*;

    localparam int MAX_REGIONS  = 16;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 800;
    localparam int DRAIN_CYCLES = MAX_REGIONS + 8;

    typedef struct {
        logic               req_type;
        logic [ADDR_W-1:0]  address;
        logic [ADDR_W-1:0]  region_length;
        logic [FLAGS_W-1:0] region_flags;
        logic [ADDR_W-1:0]  file_offset;
        logic [ADDR_W-1:0]  file_bytes;
    } region_req_t;

    typedef struct {
        logic [STAT_W-1:0]  status;
        logic [SLOT_W-1:0]  slot;
        logic [ADDR_W-1:0]  start_addr;
        logic [ADDR_W-1:0]  end_addr;
        logic [FLAGS_W-1:0] flags;
        logic [ADDR_W-1:0]  file_offset;
        logic [ADDR_W-1:0]  file_bytes;
    } region_reply_t;

    typedef struct {
        region_req_t   rq;
        logic          typed;
        region_reply_t reply;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               req_type = 1'b0;
    logic [ADDR_W-1:0]  address = '0;
    logic [ADDR_W-1:0]  region_length = '0;
    logic [FLAGS_W-1:0] region_flags = '0;
    logic [ADDR_W-1:0]  file_offset = '0;
    logic [ADDR_W-1:0]  file_bytes = '0;
    logic               busy;
    logic               done;
    logic [STAT_W-1:0]  status;
    logic [SLOT_W-1:0]  slot;
    logic [ADDR_W-1:0]  match_start;
    logic [ADDR_W-1:0]  match_end;
    logic [FLAGS_W-1:0] match_flags;
    logic [ADDR_W-1:0]  match_file_offset;
    logic [ADDR_W-1:0]  match_file_bytes;

    logic [ADDR_W-1:0]  tbl_start [MAX_REGIONS];
    logic [ADDR_W-1:0]  tbl_end   [MAX_REGIONS];
    logic [FLAGS_W-1:0] tbl_flags [MAX_REGIONS];
    logic [ADDR_W-1:0]  tbl_offset[MAX_REGIONS];
    logic [ADDR_W-1:0]  tbl_bytes [MAX_REGIONS];
    int                 tbl_count = 0;

    region_reply_t      pending_replies[$];
    stim_row_t          directed_rows[$];
    int                 errors = 0;
    int                 cycle_count = 0;
    int                 quiet_left = 0;

    address_region_table #(
        .MAX_REGIONS(MAX_REGIONS)
    ) u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .req_type          (req_type),
        .address           (address),
        .region_length     (region_length),
        .region_flags      (region_flags),
        .file_offset       (file_offset),
        .file_bytes        (file_bytes),
        .done              (done),
        .status            (status),
        .slot              (slot),
        .match_start       (match_start),
        .match_end         (match_end),
        .match_flags       (match_flags),
        .match_file_offset (match_file_offset),
        .match_file_bytes  (match_file_bytes)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic region_req_t insert_req(logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] len,
                                               logic [FLAGS_W-1:0] fl, logic [ADDR_W-1:0] off,
                                               logic [ADDR_W-1:0] nb);
        region_req_t r;
        r = '{REQ_INSERT, a, len, fl, off, nb};
        return r;
    endfunction

    function automatic region_req_t lookup_req(logic [ADDR_W-1:0] a);
        region_req_t r;
        r = '{REQ_LOOKUP, a, {$urandom, $urandom}, 8'($urandom), {$urandom, $urandom},
              {$urandom, $urandom}};
        return r;
    endfunction

    function automatic region_reply_t predict_region_reply(region_req_t rq);
        region_reply_t r;
        int            hit;
        r   = '{default: '0};
        hit = -1;
        if (rq.req_type == REQ_INSERT)
        begin
            if (tbl_count >= MAX_REGIONS)
            begin
                r.status = STATUS_FULL;
                return r;
            end
            tbl_start[tbl_count]  = rq.address;
            tbl_end[tbl_count]    = rq.address + rq.region_length;
            tbl_flags[tbl_count]  = rq.region_flags;
            tbl_offset[tbl_count] = rq.file_offset;
            tbl_bytes[tbl_count]  = rq.file_bytes;
            hit = tbl_count;
            tbl_count++;
        end
        else
        begin
            for (int i = 0; i < tbl_count; i++)
            begin
                if (hit < 0 && rq.address >= tbl_start[i] && rq.address < tbl_end[i])
                    hit = i;
            end
            if (hit < 0)
            begin
                r.status = STATUS_MISS;
                return r;
            end
        end
        r.status      = STATUS_OK;
        r.slot        = SLOT_W'(hit);
        r.start_addr  = tbl_start[hit];
        r.end_addr    = tbl_end[hit];
        r.flags       = tbl_flags[hit];
        r.file_offset = tbl_offset[hit];
        r.file_bytes  = tbl_bytes[hit];
        return r;
    endfunction

    task automatic issue_request(input region_req_t rq, input logic typed,
                                 input region_reply_t typed_reply);
        region_reply_t predicted;
        int            gap;
        start         <= 1'b1;
        req_type      <= rq.req_type;
        address       <= rq.address;
        region_length <= rq.region_length;
        region_flags  <= rq.region_flags;
        file_offset   <= rq.file_offset;
        file_bytes    <= rq.file_bytes;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        predicted = predict_region_reply(rq);
        if (typed)
            pending_replies.push_back(typed_reply);
        else
            pending_replies.push_back(predicted);
        if (quiet_left > 0)
        begin
            quiet_left--;
            gap = 0;
        end
        else
        begin
            gap = $urandom_range(0, 13);
            if ($urandom_range(0, 19) == 0)
                quiet_left = $urandom_range(8, 30);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_all_replies();
        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    function automatic void check_field(string name, logic [ADDR_W-1:0] want_v,
                                        logic [ADDR_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
        end
    endfunction

    always @(posedge clk)
    begin : reply_check
        region_reply_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_replies.size() == 0)
            begin
                errors++;
                $display("%0t: result with no transaction outstanding, expected none, actual status %0d",
                         $time, status);
            end
            else
            begin
                want = pending_replies.pop_front();
                check_field("status", 64'(want.status), 64'(status));
                check_field("slot", 64'(want.slot), 64'(slot));
                check_field("match_start", want.start_addr, match_start);
                check_field("match_end", want.end_addr, match_end);
                check_field("match_flags", 64'(want.flags), 64'(match_flags));
                check_field("match_file_offset", want.file_offset, match_file_offset);
                check_field("match_file_bytes", want.file_bytes, match_file_bytes);
            end
        end
    end

    initial
    begin : stimulus
        region_reply_t      no_reply;
        region_req_t        rq;
        logic [ADDR_W-1:0]  a;
        logic [ADDR_W-1:0]  len;
        logic [ADDR_W-1:0]  s;
        logic [ADDR_W-1:0]  e;
        int                 j;
        int                 insert_pct;

        no_reply = '{default: '0};

        // empty table, extremes of the fields, empty and wrapped regions
        directed_rows.push_back('{lookup_req(64'h0), 1'b1,
            '{STATUS_MISS, 4'd0, 64'h0, 64'h0, 8'h00, 64'h0, 64'h0}});
        directed_rows.push_back('{lookup_req('1), 1'b1,
            '{STATUS_MISS, 4'd0, 64'h0, 64'h0, 8'h00, 64'h0, 64'h0}});
        directed_rows.push_back('{insert_req(64'h1000, 64'h1000, 8'hFF, '1, '1), 1'b1,
            '{STATUS_OK, 4'd0, 64'h1000, 64'h2000, 8'hFF, '1, '1}});
        directed_rows.push_back('{insert_req(64'h5000, 64'h0, 8'h00, 64'h0, 64'h0), 1'b1,
            '{STATUS_OK, 4'd1, 64'h5000, 64'h5000, 8'h00, 64'h0, 64'h0}});
        directed_rows.push_back('{insert_req('1, '1, 8'h5A, 64'h0123_4567_89AB_CDEF,
                                             64'hFEDC_BA98_7654_3210), 1'b1,
            '{STATUS_OK, 4'd2, '1, 64'hFFFF_FFFF_FFFF_FFFE, 8'h5A, 64'h0123_4567_89AB_CDEF,
              64'hFEDC_BA98_7654_3210}});
        directed_rows.push_back('{insert_req(64'hFFFF_FFFF_FFFF_0000, 64'h1_0000, 8'h81,
                                             64'h8000_0000_0000_0000, 64'h1), 1'b1,
            '{STATUS_OK, 4'd3, 64'hFFFF_FFFF_FFFF_0000, 64'h0, 8'h81,
              64'h8000_0000_0000_0000, 64'h1}});
        directed_rows.push_back('{lookup_req(64'h1000), 1'b0, no_reply});
        directed_rows.push_back('{lookup_req(64'h1FFF), 1'b0, no_reply});
        directed_rows.push_back('{lookup_req(64'h2000), 1'b0, no_reply});
        directed_rows.push_back('{lookup_req(64'h0FFF), 1'b0, no_reply});
        directed_rows.push_back('{lookup_req(64'h5000), 1'b0, no_reply});
        directed_rows.push_back('{lookup_req('1), 1'b0, no_reply});
        directed_rows.push_back('{lookup_req(64'hFFFF_FFFF_FFFF_0000), 1'b0, no_reply});
        directed_rows.push_back('{lookup_req(64'h0), 1'b0, no_reply});
        // overlap with slot 0, first slot wins
        directed_rows.push_back('{insert_req(64'h1800, 64'h1000, 8'h3C, 64'h40, 64'h800),
                                  1'b0, no_reply});
        directed_rows.push_back('{lookup_req(64'h1800), 1'b0, no_reply});
        directed_rows.push_back('{lookup_req(64'h2000), 1'b0, no_reply});
        directed_rows.push_back('{lookup_req(64'h27FF), 1'b0, no_reply});
        directed_rows.push_back('{lookup_req(64'h2800), 1'b0, no_reply});
        directed_rows.push_back('{insert_req(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                                             8'h01, 64'h0, '1), 1'b0, no_reply});
        directed_rows.push_back('{lookup_req(64'hFFFF_FFFF_FFFF_FFFE), 1'b0, no_reply});
        directed_rows.push_back('{lookup_req('1), 1'b0, no_reply});
        directed_rows.push_back('{lookup_req(64'h7FFF_FFFF_FFFF_FFFF), 1'b0, no_reply});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_rows[k])
            issue_request(directed_rows[k].rq, directed_rows[k].typed, directed_rows[k].reply);
        wait_all_replies();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
                wait_all_replies();
            insert_pct = (tbl_count < MAX_REGIONS) ? 40 : 8;
            if ($urandom_range(0, 99) < insert_pct)
            begin
                case ($urandom_range(0, 3))
                    0: a = {$urandom, $urandom};
                    1: a = 64'($urandom_range(0, 1 << 20));
                    2: a = tbl_start[$urandom_range(0, tbl_count - 1)]
                           + 64'($urandom_range(0, 8192)) - 64'd4096;
                    default: a = ~64'($urandom_range(0, 1 << 20));
                endcase
                case ($urandom_range(0, 3))
                    0: len = 64'($urandom_range(1, 8192));
                    1: len = '0;
                    2: len = {$urandom, $urandom};
                    default: len = 64'($urandom_range(1, 1 << 24));
                endcase
                rq = insert_req(a, len, 8'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
            end
            else
            begin
                if (tbl_count == 0 || $urandom_range(0, 9) < 3)
                begin
                    case ($urandom_range(0, 2))
                        0: a = {$urandom, $urandom};
                        1: a = 64'($urandom_range(0, 1 << 20));
                        default: a = ~64'($urandom_range(0, 4095));
                    endcase
                end
                else
                begin
                    j   = $urandom_range(0, tbl_count - 1);
                    s   = tbl_start[j];
                    e   = tbl_end[j];
                    len = e - s;
                    case ($urandom_range(0, 5))
                        0: a = s;
                        1: a = e - 64'd1;
                        2: a = e;
                        3: a = s - 64'd1;
                        default: a = (len == 0) ? s : s + ({$urandom, $urandom} % len);
                    endcase
                end
                rq = lookup_req(a);
            end
            issue_request(rq, 1'b0, no_reply);
        end

        wait_all_replies();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
